/* rtl/ship_pkg.sv */
// ----------------------------------------------------------------------------
// ship_pkg: shared types and constants
// Row layouts, transaction types and sizing for the replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ship_pkg;

    localparam int SET_COUNT     = 2048;
    localparam int SET_W         = $clog2(SET_COUNT);
    localparam int WAY_COUNT     = 16;
    localparam int WAY_W         = $clog2(WAY_COUNT);
    localparam int LEADER_COUNT  = 64;
    localparam int SIG_COUNT     = 64;
    localparam int SIG_W         = $clog2(SIG_COUNT);
    localparam int SIG_LSB       = 4;
    localparam int ADDR_LOW_W    = 16;
    localparam int SEL_W         = 10;
    localparam int SEL_THRESHOLD = 512;
    localparam int PADDR_W       = 48;
    localparam int PC_W          = 48;

    typedef enum logic {
        OP_FIND   = 1'b0,
        OP_UPDATE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [SET_W-1:0]      set_idx;
        logic [WAY_W-1:0]      way;
        logic [ADDR_LOW_W-1:0] paddr_low;
        logic [SIG_W-1:0]      sig;
        logic                  hit;
        logic                  draw;
    } t_item;

    typedef struct packed {
        logic [WAY_W-1:0] victim_way;
        logic [1:0]       insert_depth;
        logic             streaming;
    } t_result;

    typedef struct packed {
        logic [WAY_COUNT-1:0][1:0]       age;
        logic [WAY_COUNT-1:0][SIG_W-1:0] sig;
    } t_blk_row;

    typedef struct packed {
        logic [SIG_COUNT-1:0][1:0] reuse;
        logic [1:0]                conf;
        logic [ADDR_LOW_W-1:0]     prev_addr;
        logic [ADDR_LOW_W-1:0]     prev_stride;
    } t_set_row;

    localparam t_blk_row BLK_RESET = '{age: '1, sig: '0};
    localparam t_set_row SET_RESET = '{reuse: {SIG_COUNT{2'b01}}, conf: '0,
                                       prev_addr: '0, prev_stride: '0};

endpackage

`default_nettype wire

/* rtl/ship_rrip_stream_replacement_core.sv */
// ----------------------------------------------------------------------------
// ship_rrip_stream_replacement_core: cache replacement engine
// Victim selection and access update over per-set state memories.
//
// Input channel (i_valid/o_stall) carries one transaction: a find or an
// update of one set. Output channel (o_valid/i_stall) returns one result
// per transaction, in order. The config channel (i_cfg_valid/o_cfg_ready)
// writes the 10-bit dueling selector; it is always ready.
// Each transaction: the set's rows are read from the block and set memories
// on the accept edge, then modified and written back in S_CALC on the edge
// where the result enters the output register. One transaction is in flight,
// set by the memory read-modify-write: a new one is taken only after the
// last is written back. While a result waits under i_stall a new transaction
// is still accepted; it holds in its write-back cycle until the output
// register frees.
// After reset a clearing pass writes all 2048 rows of both memories, one
// row per cycle, with o_stall high throughout the pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_rrip_stream_replacement_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic                            i_operation,
    input  wire logic [ship_pkg::SET_W-1:0]      i_set_index,
    input  wire logic [ship_pkg::WAY_W-1:0]      i_way,
    input  wire logic [ship_pkg::PADDR_W-1:0]    i_paddr,
    input  wire logic [ship_pkg::PC_W-1:0]       i_pc,
    input  wire logic                            i_hit,
    input  wire logic                            i_bimodal_draw,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic [ship_pkg::WAY_W-1:0]           o_victim_way,
    output logic [1:0]                           o_insert_depth,
    output logic                                 o_streaming,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [ship_pkg::SEL_W-1:0]      i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CALC  = 3'b100
    } t_state;

    t_state                       r_state, n_state;
    logic [ship_pkg::SET_W-1:0]   r_clr;
    logic [ship_pkg::SEL_W-1:0]   r_sel;
    ship_pkg::t_item              r_item;
    ship_pkg::t_result            r_out;
    logic                         r_out_valid;

    ship_pkg::t_item    in_item;
    ship_pkg::t_blk_row blk_rd, blk_new, blk_wr;
    ship_pkg::t_set_row set_rd, set_new, set_wr;
    ship_pkg::t_result  res;
    logic               accept;
    logic               fire;
    logic               mem_we;
    logic [ship_pkg::SET_W-1:0] waddr;

    assign in_item = '{op: ship_pkg::t_op'(i_operation), set_idx: i_set_index,
                       way: i_way, paddr_low: i_paddr[ship_pkg::ADDR_LOW_W-1:0],
                       sig: i_pc[ship_pkg::SIG_LSB +: ship_pkg::SIG_W],
                       hit: i_hit, draw: i_bimodal_draw};

    assign o_stall     = (r_state != S_IDLE);
    assign accept      = i_valid && !o_stall;
    assign fire        = (r_state == S_CALC) && (!r_out_valid || !i_stall);
    assign o_cfg_ready = 1'b1;

    assign mem_we = (r_state == S_CLEAR) || fire;
    assign waddr  = (r_state == S_CLEAR) ? r_clr : r_item.set_idx;
    assign blk_wr = (r_state == S_CLEAR) ? ship_pkg::BLK_RESET : blk_new;
    assign set_wr = (r_state == S_CLEAR) ? ship_pkg::SET_RESET : set_new;

    ship_ram #(
        .WIDTH ($bits(ship_pkg::t_blk_row)),
        .DEPTH (ship_pkg::SET_COUNT)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (blk_wr),
        .i_re    (accept),
        .i_raddr (i_set_index),
        .o_rdata (blk_rd)
    );

    ship_ram #(
        .WIDTH ($bits(ship_pkg::t_set_row)),
        .DEPTH (ship_pkg::SET_COUNT)
    ) u_set_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (set_wr),
        .i_re    (accept),
        .i_raddr (i_set_index),
        .o_rdata (set_rd)
    );

    ship_dp u_dp (
        .i_item (r_item),
        .i_blk  (blk_rd),
        .i_setr (set_rd),
        .i_sel  (r_sel),
        .o_blk  (blk_new),
        .o_setr (set_new),
        .o_res  (res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ship_pkg::SET_W'(ship_pkg::SET_COUNT - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) n_state = S_CALC;
            end
            S_CALC: begin
                if (fire) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_sel       <= ship_pkg::SEL_W'(ship_pkg::SEL_THRESHOLD);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cfg_valid && o_cfg_ready) r_sel <= i_cfg_data;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= in_item;
        if (fire)   r_out  <= res;
    end

    assign o_valid        = r_out_valid;
    assign o_victim_way   = r_out.victim_way;
    assign o_insert_depth = r_out.insert_depth;
    assign o_streaming    = r_out.streaming;

endmodule

`default_nettype wire

/* rtl/ship_ram.sv */
// ----------------------------------------------------------------------------
// ship_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data valid one cycle after the read.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/ship_dp.sv */
// ----------------------------------------------------------------------------
// ship_dp: read-modify-write datapath
// Victim search with set aging, stride detector, reuse counters, insertion.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_dp (
    input  wire ship_pkg::t_item                   i_item,
    input  wire ship_pkg::t_blk_row                i_blk,
    input  wire ship_pkg::t_set_row                i_setr,
    input  wire logic [ship_pkg::SEL_W-1:0]        i_sel,
    output ship_pkg::t_blk_row                     o_blk,
    output ship_pkg::t_set_row                     o_setr,
    output ship_pkg::t_result                      o_res
);

    always_comb begin
        logic [ship_pkg::ADDR_LOW_W-1:0] stride;
        logic [1:0]                      conf;
        logic                            strm;
        logic [1:0]                      mx;
        logic [1:0]                      dlt;
        logic [ship_pkg::WAY_W-1:0]      vic;
        logic [2:0]                      sum;
        logic [ship_pkg::SIG_W-1:0]      osig;
        logic [1:0]                      cnt;
        logic [1:0]                      bim;
        logic [1:0]                      dep;

        o_blk  = i_blk;
        o_setr = i_setr;
        o_res  = '0;

        stride = i_item.paddr_low - i_setr.prev_addr;
        conf   = i_setr.conf;
        if (stride == i_setr.prev_stride && stride != '0) begin
            if (conf != 2'd3) conf = conf + 2'd1;
        end else if (conf != 2'd0) begin
            conf = conf - 2'd1;
        end
        strm = conf[1];

        mx = 2'd0;
        for (int w = 0; w < ship_pkg::WAY_COUNT; w++) begin
            if (i_blk.age[w] > mx) mx = i_blk.age[w];
        end
        dlt = 2'd3 - mx;
        vic = '0;
        for (int w = ship_pkg::WAY_COUNT - 1; w >= 0; w--) begin
            if (i_blk.age[w] == mx) vic = ship_pkg::WAY_W'(w);
        end

        bim  = i_item.draw ? 2'd2 : 2'd3;
        dep  = 2'd0;
        osig = i_blk.sig[i_item.way];
        cnt  = 2'd0;
        sum  = 3'd0;

        if (i_item.op == ship_pkg::OP_FIND) begin
            for (int w = 0; w < ship_pkg::WAY_COUNT; w++) begin
                sum = {1'b0, i_blk.age[w]} + {1'b0, dlt};
                o_blk.age[w] = (sum > 3'd3) ? 2'd3 : sum[1:0];
            end
            o_res.victim_way = vic;
        end else begin
            o_setr.conf        = conf;
            o_setr.prev_stride = stride;
            o_setr.prev_addr   = i_item.paddr_low;
            o_res.streaming    = strm;
            if (i_item.hit) begin
                cnt = i_setr.reuse[i_item.sig];
                if (cnt != 2'd3) o_setr.reuse[i_item.sig] = cnt + 2'd1;
                o_blk.age[i_item.way] = 2'd0;
            end else begin
                if (i_setr.reuse[osig] != 2'd0) begin
                    o_setr.reuse[osig] = i_setr.reuse[osig] - 2'd1;
                end
                o_blk.sig[i_item.way] = i_item.sig;
                if (i_item.set_idx < ship_pkg::SET_W'(ship_pkg::LEADER_COUNT)) begin
                    dep = 2'd3;
                end else if (i_item.set_idx >= ship_pkg::SET_W'(ship_pkg::SET_COUNT
                                                 - ship_pkg::LEADER_COUNT)) begin
                    dep = bim;
                end else begin
                    dep = (i_sel >= ship_pkg::SEL_W'(ship_pkg::SEL_THRESHOLD)) ? 2'd3 : bim;
                end
                cnt = o_setr.reuse[i_item.sig];
                if (strm) begin
                    dep = 2'd3;
                end else if (cnt >= 2'd2) begin
                    dep = 2'd1;
                end
                o_blk.age[i_item.way] = dep;
                o_res.insert_depth    = dep;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/ship_chk.sv */
// ----------------------------------------------------------------------------
// ship_chk: port-level checker
// Watches the top-level ports of the replacement engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_chk (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         o_valid,
    input wire logic                         i_stall,
    input wire logic                         o_stall,
    input wire logic [ship_pkg::WAY_W-1:0]   o_victim_way,
    input wire logic [1:0]                   o_insert_depth,
    input wire logic                         o_streaming
);

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_victim_way) && $stable(o_insert_depth)
                               && $stable(o_streaming))
        else $error("stalled result changed");

    a_find_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_victim_way != '0 |-> o_insert_depth == 2'd0 && !o_streaming)
        else $error("find result carries update fields");

    a_stream_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_streaming && o_insert_depth != 2'd0 |-> o_insert_depth == 2'd3)
        else $error("streaming fill not inserted distant");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_stall)
        else $error("accepting during clearing pass");

endmodule

bind ship_rrip_stream_replacement_core ship_chk u_chk (.*);

`default_nettype wire

/* tb/sv/ship_rrip_stream_replacement_core_tb.sv */
// ----------------------------------------------------------------------------
// ship_rrip_stream_replacement_core_tb: self-checking replacement engine bench
// Drives find and update transactions in random bursts against a cycle-free
// model of the ages, signatures, reuse counters and stride detector, steps the
// dueling selector through several settings, and checks every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ship_rrip_stream_replacement_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ship_pkg::*;

    localparam int IDLE_LIMIT = 6000;

    typedef struct {
        t_op               op;
        logic [SET_W-1:0]  set_index;
        logic [WAY_W-1:0]  way;
        logic [PADDR_W-1:0] paddr;
        logic [PC_W-1:0]   pc;
        logic              hit;
        logic              draw;
    } t_access;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic                  i_operation = 1'b0;
    logic [SET_W-1:0]      i_set_index = '0;
    logic [WAY_W-1:0]      i_way = '0;
    logic [PADDR_W-1:0]    i_paddr = '0;
    logic [PC_W-1:0]       i_pc = '0;
    logic                  i_hit = 1'b0;
    logic                  i_bimodal_draw = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [WAY_W-1:0]      o_victim_way;
    logic [1:0]            o_insert_depth;
    logic                  o_streaming;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [SEL_W-1:0]      i_cfg_data = '0;

    ship_rrip_stream_replacement_core uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [1:0]            age_mem   [SET_COUNT][WAY_COUNT];
    logic [SIG_W-1:0]      sig_mem   [SET_COUNT][WAY_COUNT];
    logic [1:0]            reuse_mem [SET_COUNT][SIG_COUNT];
    logic [1:0]            conf_mem  [SET_COUNT];
    logic [ADDR_LOW_W-1:0] prev_low_mem [SET_COUNT];
    logic [ADDR_LOW_W-1:0] last_stride [SET_COUNT];
    logic [SEL_W-1:0]      selector;

    t_access  pending_accesses[$];
    t_result  expected_results[$];
    int       errors = 0;
    int       n_find = 0, n_hit = 0, n_fill = 0, n_stream = 0, n_aged = 0;
    bit       took = 1'b0;

    function automatic t_result predict_access(input t_access a);
        int s, w, r;
        bit found;
        logic [SIG_W-1:0] sg, osg;
        logic [ADDR_LOW_W-1:0] low, stride;
        logic [1:0] depth, bim;
        bit strm;
        t_result res;
        s = a.set_index;
        w = a.way;
        res = '0;
        if (a.op == OP_FIND) begin
            found = 0;
            n_find++;
            for (r = 0; r < 4 && !found; r++) begin
                for (int k = 0; k < WAY_COUNT; k++) begin
                    if (!found && age_mem[s][k] == 2'd3) begin
                        res.victim_way = WAY_W'(k);
                        found = 1;
                    end
                end
                if (!found) begin
                    n_aged++;
                    for (int k = 0; k < WAY_COUNT; k++)
                        if (age_mem[s][k] != 2'd3) age_mem[s][k]++;
                end
            end
            return res;
        end
        low = a.paddr[ADDR_LOW_W-1:0];
        stride = low - prev_low_mem[s];
        if (stride == last_stride[s] && stride != 0) begin
            if (conf_mem[s] != 2'd3) conf_mem[s]++;
        end else if (conf_mem[s] != 2'd0) begin
            conf_mem[s]--;
        end
        last_stride[s] = stride;
        prev_low_mem[s] = low;
        strm = conf_mem[s] >= 2;
        sg = a.pc[SIG_LSB +: SIG_W];
        if (a.hit) begin
            n_hit++;
            if (reuse_mem[s][sg] != 2'd3) reuse_mem[s][sg]++;
            age_mem[s][w] = 2'd0;
            depth = 2'd0;
        end else begin
            n_fill++;
            osg = sig_mem[s][w];
            bim = a.draw ? 2'd2 : 2'd3;
            if (reuse_mem[s][osg] != 2'd0) reuse_mem[s][osg]--;
            sig_mem[s][w] = sg;
            if (s < LEADER_COUNT) depth = 2'd3;
            else if (s + LEADER_COUNT >= SET_COUNT) depth = bim;
            else depth = (selector >= SEL_THRESHOLD) ? 2'd3 : bim;
            if (strm) depth = 2'd3;
            else if (reuse_mem[s][sg] >= 2) depth = 2'd1;
            age_mem[s][w] = depth;
        end
        if (strm) n_stream++;
        res.insert_depth = depth;
        res.streaming = strm;
        return res;
    endfunction

    // model state, input acceptance and result checking
    always @(posedge i_clk) begin
        t_access a;
        t_result got, want;
        took <= i_valid && !o_stall;
        if (i_rst_n && i_cfg_valid && o_cfg_ready) selector = i_cfg_data;
        if (i_rst_n && i_valid && !o_stall) begin
            a.op = t_op'(i_operation);
            a.set_index = i_set_index;
            a.way = i_way;
            a.paddr = i_paddr;
            a.pc = i_pc;
            a.hit = i_hit;
            a.draw = i_bimodal_draw;
            expected_results.push_back(predict_access(a));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{victim_way: o_victim_way, insert_depth: o_insert_depth,
                    streaming: o_streaming};
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.victim_way !== want.victim_way) begin
                    $display("%0t: victim_way expected %0d actual %0d",
                             $realtime, want.victim_way, got.victim_way);
                    errors++;
                end
                if (got.insert_depth !== want.insert_depth) begin
                    $display("%0t: insert_depth expected %0d actual %0d",
                             $realtime, want.insert_depth, got.insert_depth);
                    errors++;
                end
                if (got.streaming !== want.streaming) begin
                    $display("%0t: streaming expected %0d actual %0d",
                             $realtime, want.streaming, got.streaming);
                    errors++;
                end
            end
        end
    end

    int gap_left = 0, burst_left = 4;

    // drive transactions in bursts
    always @(negedge i_clk) begin
        t_access a;
        if (i_rst_n && (!i_valid || took)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_accesses.size() > 0) begin
                a = pending_accesses.pop_front();
                i_operation <= a.op;
                i_set_index <= a.set_index;
                i_way <= a.way;
                i_paddr <= a.paddr;
                i_pc <= a.pc;
                i_hit <= a.hit;
                i_bimodal_draw <= a.draw;
                i_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    int stall_mode = 0, stall_left = 0;

    // receiver back-pressure pattern
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 120);
        end
        stall_left--;
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 9) < 3);
            2: i_stall <= (stall_left % 17) < 9;
            default: i_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    int idle_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    logic [ADDR_LOW_W-1:0] stream_next [SET_COUNT];
    logic [ADDR_LOW_W-1:0] stream_step [SET_COUNT];
    int hot_sets[12] = '{0, 7, 63, 64, 65, 300, 1000, 1500, 1983, 1984, 2000, 2047};

    function automatic t_access make_access(input t_op op, input int s, input int w,
                                            input logic [47:0] paddr, input logic [47:0] pc,
                                            input bit hit, input bit draw);
        t_access a;
        a.op = op;
        a.set_index = SET_W'(s);
        a.way = WAY_W'(w);
        a.paddr = paddr;
        a.pc = pc;
        a.hit = hit;
        a.draw = draw;
        return a;
    endfunction

    function automatic t_access random_access();
        int s;
        logic [47:0] paddr, pc;
        s = ($urandom_range(0, 9) < 8) ? hot_sets[$urandom_range(0, 11)]
                                      : $urandom_range(0, SET_COUNT - 1);
        paddr = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 7) begin
            if ($urandom_range(0, 15) == 0)
                stream_step[s] = ADDR_LOW_W'($urandom_range(0, 3) * 64);
            paddr[15:0] = stream_next[s];
        end
        stream_next[s] = paddr[15:0] + stream_step[s];
        pc = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 7) pc[9:4] = SIG_W'($urandom_range(0, 5));
        return make_access(($urandom_range(0, 9) < 3) ? OP_FIND : OP_UPDATE, s,
                           $urandom_range(0, 15), paddr, pc, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)));
    endfunction

    task automatic drain();
        while (pending_accesses.size() != 0 || i_valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_selector(input logic [SEL_W-1:0] v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [SEL_W-1:0] settings[6];
        logic [47:0] ones;
        ones = '1;
        settings = '{10'd0, 10'd1023, 10'd511, 10'd512, 10'd0, 10'd0};
        settings[5] = SEL_W'($urandom_range(0, 1023));
        for (int s = 0; s < SET_COUNT; s++) begin
            for (int w = 0; w < WAY_COUNT; w++) begin
                age_mem[s][w] = 2'd3;
                sig_mem[s][w] = '0;
            end
            for (int g = 0; g < SIG_COUNT; g++) reuse_mem[s][g] = 2'd1;
            conf_mem[s] = '0;
            prev_low_mem[s] = '0;
            last_stride[s] = '0;
            stream_next[s] = ADDR_LOW_W'($urandom);
            stream_step[s] = ADDR_LOW_W'($urandom_range(1, 8) * 16);
        end
        selector = SEL_THRESHOLD;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_selector(10'd512);

        pending_accesses.push_back(make_access(OP_FIND, 0, 0, 0, 0, 0, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 0, 15, 0, 0, 0, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 2047, 15, ones, ones, 1, 1));
        pending_accesses.push_back(make_access(OP_UPDATE, 2047, 3, 48'h10, 0, 0, 1));
        pending_accesses.push_back(make_access(OP_UPDATE, 2047, 4, 48'h20, 0, 0, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 1000, 1, 48'h5, 48'h30, 0, 1));
        pending_accesses.push_back(make_access(OP_UPDATE, 1000, 2, 48'h9, 48'h30, 0, 0));
        for (int k = 1; k <= 5; k++)
            pending_accesses.push_back(make_access(OP_UPDATE, 7, k, 48'(k * 64), 48'h40,
                                                   0, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 8, 0, 0, 0, 0, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 8, 0, 0, 0, 0, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 9, 0, 48'h3, 48'h50, 1, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 9, 1, 48'h7, 48'h50, 1, 0));
        pending_accesses.push_back(make_access(OP_UPDATE, 9, 2, 48'h1, 48'h50, 0, 1));
        pending_accesses.push_back(make_access(OP_FIND, 9, 0, 0, 0, 0, 0));
        pending_accesses.push_back(make_access(OP_FIND, 2047, 0, ones, ones, 1, 1));
        for (int k = 0; k < 4; k++)
            pending_accesses.push_back(make_access(OP_UPDATE, 300, k, 48'(k), ones, 1, 0));
        pending_accesses.push_back(make_access(OP_FIND, 300, 0, 0, 0, 0, 0));

        for (int p = 0; p < 6; p++) begin
            for (int k = 0; k < 290; k++) pending_accesses.push_back(random_access());
            drain();
            write_selector(settings[p]);
        end
        drain();
        $display("run: %0d finds (%0d aging rounds), %0d hits, %0d fills",
                 n_find, n_aged, n_hit, n_fill);
        $display("run: %0d streaming updates, 7 selector settings", n_stream);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
